FILE: hw/rtl/fnps_pkg.sv
// fnps_pkg: shared types, register codes, constants and lookup tables
// for the fm note preview sequencer (front, queue and back modules)
// no dependencies
`timescale 1ns / 1ps

package fnps_pkg;

  // command codes of an input beat
  localparam logic CMD_PARAM = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  // result kinds
  localparam logic KIND_FM_WRITE = 1'b0;
  localparam logic KIND_STOP     = 1'b1;

  // parameter index codes outside the per-operator range
  localparam logic [3:0] PI_ALG = 4'd10;
  localparam logic [3:0] PI_FB  = 4'd11;

  // patch store layout
  localparam int unsigned PATCH_BYTES = 42;
  localparam int unsigned PATCH_AW    = $clog2(PATCH_BYTES);
  localparam logic [PATCH_AW-1:0] ENTRY_ALG  = PATCH_AW'(40);
  localparam logic [PATCH_AW-1:0] ENTRY_FB   = PATCH_AW'(41);
  localparam logic [PATCH_AW-1:0] ENTRY_LAST = PATCH_AW'(PATCH_BYTES - 1);

  // operator register groups, in emit order
  localparam logic [2:0] OPR_DT_MUL = 3'd0;
  localparam logic [2:0] OPR_TL     = 3'd1;
  localparam logic [2:0] OPR_KS_AR  = 3'd2;
  localparam logic [2:0] OPR_DR     = 3'd3;
  localparam logic [2:0] OPR_SR     = 3'd4;
  localparam logic [2:0] OPR_SL_RR  = 3'd5;
  localparam logic [2:0] OPR_SSG    = 3'd6;
  localparam logic [1:0] OP_LAST    = 2'd3;

  // fm register addresses and fixed data
  localparam logic [7:0] ADDR_KEY      = 8'h28;
  localparam logic [7:0] ADDR_ALG_FB   = 8'hB0;
  localparam logic [7:0] ADDR_PAN      = 8'hB4;
  localparam logic [7:0] DATA_PAN      = 8'hC0;
  localparam logic [7:0] ADDR_FNUM_HI  = 8'hA4;
  localparam logic [7:0] ADDR_FNUM_LO  = 8'hA0;
  localparam logic [7:0] KEY_ON_MASK   = 8'hF0;
  localparam logic [3:0] OP_ADDR_FIRST = 4'h3;

  localparam logic [1:0] CHANNEL_RESET = 2'd2;

  // defaults for top level parameters
  localparam int unsigned PITCH_TABLE_DEPTH = 108;
  localparam int unsigned QUEUE_DEPTH       = 2;

  // pitch table: block in [13:11], fnum in [10:0]
  localparam int unsigned PITCH_ROM_ENTRIES = 108;
  localparam logic [13:0] PITCH_ROM [PITCH_ROM_ENTRIES] = '{
    14'h0142, 14'h0155, 14'h0169, 14'h017f, 14'h0196, 14'h01ae, 14'h01c7, 14'h01e2,
    14'h01ff, 14'h021d, 14'h023e, 14'h0260, 14'h0284, 14'h02aa, 14'h02d3, 14'h02fe,
    14'h032b, 14'h035b, 14'h038e, 14'h03c5, 14'h03fe, 14'h043b, 14'h047b, 14'h04bf,
    14'h0508, 14'h0554, 14'h05a5, 14'h05fb, 14'h0656, 14'h06b7, 14'h071d, 14'h0789,
    14'h07fc, 14'h0c3b, 14'h0c7b, 14'h0cbf, 14'h0d08, 14'h0d54, 14'h0da5, 14'h0dfb,
    14'h0e56, 14'h0eb7, 14'h0f1d, 14'h0f89, 14'h0ffc, 14'h143b, 14'h147b, 14'h14bf,
    14'h1508, 14'h1554, 14'h15a5, 14'h15fb, 14'h1656, 14'h16b7, 14'h171d, 14'h1789,
    14'h17fc, 14'h1c3b, 14'h1c7b, 14'h1cbf, 14'h1d08, 14'h1d54, 14'h1da5, 14'h1dfb,
    14'h1e56, 14'h1eb7, 14'h1f1d, 14'h1f89, 14'h1ffc, 14'h243b, 14'h247b, 14'h24bf,
    14'h2508, 14'h2554, 14'h25a5, 14'h25fb, 14'h2656, 14'h26b7, 14'h271d, 14'h2789,
    14'h27fc, 14'h2c3b, 14'h2c7b, 14'h2cbf, 14'h2d08, 14'h2d54, 14'h2da5, 14'h2dfb,
    14'h2e56, 14'h2eb7, 14'h2f1d, 14'h2f89, 14'h2ffc, 14'h343b, 14'h347b, 14'h34bf,
    14'h3508, 14'h3554, 14'h35a5, 14'h35fb, 14'h3656, 14'h36b7, 14'h371d, 14'h3789,
    14'h37fc, 14'h3c3b, 14'h3c7b, 14'h3cbf
  };

  // classified beat passed from front to back
  typedef struct packed {
    logic                is_tick;
    logic [PATCH_AW-1:0] entry;
    logic [7:0]          value;
    logic                now;
    logic                prior;
    logic [6:0]          note;
  } fnps_item_t;

  // back sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_UPD,
    ST_STOP,
    ST_KEYOFF,
    ST_ALGFB,
    ST_PAN,
    ST_OPREG,
    ST_PITCH_HI,
    ST_PITCH_LO,
    ST_KEYON
  } fnps_state_t;

  // first patch entry of an operator: op * 10
  function automatic logic [PATCH_AW-1:0] fnps_op_base(input logic [1:0] op);
    return {1'b0, op, 3'b000} + {3'b000, op, 1'b0};
  endfunction

  // first patch entry used by an operator register group
  function automatic logic [3:0] fnps_reg_offset(input logic [2:0] grp);
    logic [3:0] off;
    unique case (grp)
      OPR_DT_MUL: off = 4'd0;
      OPR_TL:     off = 4'd2;
      OPR_KS_AR:  off = 4'd3;
      OPR_DR:     off = 4'd5;
      OPR_SR:     off = 4'd6;
      OPR_SL_RR:  off = 4'd7;
      OPR_SSG:    off = 4'd9;
      default:    off = 4'd0;
    endcase
    return off;
  endfunction

  // hardware slot of an operator: order 0, 2, 1, 3
  function automatic logic [1:0] fnps_slot(input logic [1:0] op);
    return {op[0], op[1]};
  endfunction

  function automatic logic [13:0] fnps_pitch(input logic [6:0] idx);
    return PITCH_ROM[idx];
  endfunction

endpackage

FILE: hw/rtl/fnps_front.sv
// fnps_front: accepts input beats, drops unused parameter writes and
// maps parameter writes to patch entries before queueing
// depends on fnps_pkg
`timescale 1ns / 1ps

module fnps_front (
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 cmd,
  input  logic [1:0]           op_index,
  input  logic [3:0]           param_index,
  input  logic [7:0]           param_value,
  input  logic                 button_now,
  input  logic                 button_before,
  input  logic [6:0]           note_offset,
  input  logic                 q_full,
  output logic                 q_push,
  output fnps_pkg::fnps_item_t q_item
);

  logic keep;

  // stall only while the queue has no room
  assign item_stall = q_full;

  // frame ticks always go through, writes only for known parameters
  assign keep   = (cmd == fnps_pkg::CMD_FRAME) || (param_index <= fnps_pkg::PI_FB);
  assign q_push = item_valid && !q_full && keep;

  // classify the beat
  always_comb begin
    q_item.is_tick = (cmd == fnps_pkg::CMD_FRAME);
    q_item.value   = param_value;
    q_item.now     = button_now;
    q_item.prior   = button_before;
    q_item.note    = note_offset;
    if (param_index < fnps_pkg::PI_ALG) begin
      q_item.entry = fnps_pkg::fnps_op_base(op_index) + fnps_pkg::PATCH_AW'(param_index);
    end else if (param_index == fnps_pkg::PI_ALG) begin
      q_item.entry = fnps_pkg::ENTRY_ALG;
    end else begin
      q_item.entry = fnps_pkg::ENTRY_FB;
    end
  end

endmodule

FILE: hw/rtl/fnps_queue.sv
// fnps_queue: short first-in first-out queue of classified beats
// between the front and the back
// depends on fnps_pkg
`timescale 1ns / 1ps

module fnps_queue #(
  parameter int unsigned DEPTH = fnps_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fnps_pkg::fnps_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output fnps_pkg::fnps_item_t head,
  output logic                 empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fnps_pkg::fnps_item_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/fnps_back.sv
// fnps_back: patch store, preview state and the sequencer that emits
// register write beats through an output register
// depends on fnps_pkg
`timescale 1ns / 1ps

module fnps_back #(
  parameter int unsigned PITCH_TABLE_DEPTH = fnps_pkg::PITCH_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_channel,
  input  logic                 q_empty,
  input  fnps_pkg::fnps_item_t q_head,
  output logic                 q_pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 kind,
  output logic [7:0]           reg_addr,
  output logic [7:0]           reg_data,
  output logic                 last
);

  localparam int unsigned AW = fnps_pkg::PATCH_AW;
  localparam int unsigned PITCH_LAST_I =
    ((PITCH_TABLE_DEPTH < fnps_pkg::PITCH_ROM_ENTRIES) ?
     PITCH_TABLE_DEPTH : fnps_pkg::PITCH_ROM_ENTRIES) - 1;
  localparam logic [6:0] PITCH_LAST = 7'(PITCH_LAST_I);

  fnps_pkg::fnps_state_t state, state_next;

  // patch memories
  logic [7:0] staged_mem  [fnps_pkg::PATCH_BYTES];
  logic [7:0] applied_mem [fnps_pkg::PATCH_BYTES];
  logic [fnps_pkg::PATCH_BYTES-1:0] staged_vld;
  logic [fnps_pkg::PATCH_BYTES-1:0] diff;

  logic [1:0]    channel;
  logic          active, active_next;
  logic [6:0]    last_note, last_note_next;
  logic          retrig, retrig_next;
  logic          need_koff, need_koff_next;
  logic [1:0]    op_cnt, op_cnt_next;
  logic [2:0]    grp_cnt, grp_cnt_next;
  logic [6:0]    note_q;
  logic [AW-1:0] wr_entry;
  logic [7:0]    wr_value;

  // read side
  logic          rd_en;
  logic [AW-1:0] rd_addr, rd_addr_b;
  logic [7:0]    rd_a, rd_b, app_rd;
  logic          rd_a_vld, rd_b_vld;
  logic [7:0]    sa, sb;

  // control strobes
  logic          load;
  logic          diff_clear;
  logic          wr_upd;
  logic          new_diff;
  logic [7:0]    old_applied;
  logic          out_free;
  logic          changed;
  logic          retrig_c;
  logic          pitch_c;
  logic          res_kind;
  logic [7:0]    res_addr, res_data;
  logic          res_last;

  logic [6:0]    pitch_idx;
  logic [13:0]   pitch_ent;
  logic [1:0]    slot;

  assign out_free  = !result_valid || !result_stall;
  assign changed   = |diff;
  assign rd_addr_b = (rd_addr == fnps_pkg::ENTRY_LAST) ? rd_addr : rd_addr + 1'b1;

  // unwritten staged bytes read as zero
  assign sa = rd_a_vld ? rd_a : 8'h00;
  assign sb = rd_b_vld ? rd_b : 8'h00;

  // applied byte equals staged unless marked different
  assign old_applied = diff[wr_entry] ? app_rd : sa;
  assign new_diff    = (wr_value != old_applied);

  // pitch lookup with the note clamped to the table
  assign pitch_idx = (note_q > PITCH_LAST) ? PITCH_LAST : note_q;
  assign pitch_ent = fnps_pkg::fnps_pitch(pitch_idx);
  assign slot      = fnps_pkg::fnps_slot(op_cnt);

  // decision on a frame tick at the queue head
  assign retrig_c = !q_head.prior || !active || changed;
  assign pitch_c  = active && !retrig_c && (q_head.note != last_note);

  // sequencer next state and result formatting
  always_comb begin
    state_next     = state;
    active_next    = active;
    last_note_next = last_note;
    retrig_next    = retrig;
    need_koff_next = need_koff;
    op_cnt_next    = op_cnt;
    grp_cnt_next   = grp_cnt;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    load           = 1'b0;
    diff_clear     = 1'b0;
    wr_upd         = 1'b0;
    res_kind       = fnps_pkg::KIND_FM_WRITE;
    res_addr       = 8'h00;
    res_data       = 8'h00;
    res_last       = 1'b0;

    unique case (state)
      fnps_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (!q_head.is_tick) begin
            rd_en      = 1'b1;
            rd_addr    = q_head.entry;
            state_next = fnps_pkg::ST_WR_UPD;
          end else if (!q_head.now) begin
            active_next = 1'b0;
            if (q_head.prior) begin
              retrig_next = 1'b0;
              state_next  = fnps_pkg::ST_KEYOFF;
            end
          end else if (retrig_c) begin
            retrig_next    = 1'b1;
            need_koff_next = active;
            active_next    = 1'b1;
            last_note_next = q_head.note;
            diff_clear     = 1'b1;
            state_next     = fnps_pkg::ST_STOP;
          end else if (pitch_c) begin
            retrig_next    = 1'b0;
            last_note_next = q_head.note;
            diff_clear     = 1'b1;
            state_next     = fnps_pkg::ST_PITCH_HI;
          end
        end
      end

      fnps_pkg::ST_WR_UPD: begin
        wr_upd     = 1'b1;
        state_next = fnps_pkg::ST_IDLE;
      end

      fnps_pkg::ST_STOP: begin
        res_kind = fnps_pkg::KIND_STOP;
        if (out_free) begin
          load = 1'b1;
          if (need_koff) begin
            state_next = fnps_pkg::ST_KEYOFF;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = fnps_pkg::ENTRY_ALG;
            state_next = fnps_pkg::ST_ALGFB;
          end
        end
      end

      fnps_pkg::ST_KEYOFF: begin
        res_addr = fnps_pkg::ADDR_KEY;
        res_data = {6'b000000, channel};
        res_last = !retrig;
        if (out_free) begin
          load = 1'b1;
          if (retrig) begin
            rd_en      = 1'b1;
            rd_addr    = fnps_pkg::ENTRY_ALG;
            state_next = fnps_pkg::ST_ALGFB;
          end else begin
            state_next = fnps_pkg::ST_IDLE;
          end
        end
      end

      fnps_pkg::ST_ALGFB: begin
        res_addr = fnps_pkg::ADDR_ALG_FB | {6'b000000, channel};
        res_data = {2'b00, sb[2:0], sa[2:0]};
        if (out_free) begin
          load       = 1'b1;
          state_next = fnps_pkg::ST_PAN;
        end
      end

      fnps_pkg::ST_PAN: begin
        res_addr = fnps_pkg::ADDR_PAN | {6'b000000, channel};
        res_data = fnps_pkg::DATA_PAN;
        if (out_free) begin
          load         = 1'b1;
          op_cnt_next  = 2'd0;
          grp_cnt_next = fnps_pkg::OPR_DT_MUL;
          rd_en        = 1'b1;
          rd_addr      = fnps_pkg::fnps_op_base(2'd0) +
                         AW'(fnps_pkg::fnps_reg_offset(fnps_pkg::OPR_DT_MUL));
          state_next   = fnps_pkg::ST_OPREG;
        end
      end

      fnps_pkg::ST_OPREG: begin
        res_addr = {fnps_pkg::OP_ADDR_FIRST + {1'b0, grp_cnt}, slot, channel};
        unique case (grp_cnt)
          fnps_pkg::OPR_DT_MUL: res_data = {1'b0, sa[2:0], sb[3:0]};
          fnps_pkg::OPR_TL:     res_data = {1'b0, sa[6:0]};
          fnps_pkg::OPR_KS_AR:  res_data = {sa[1:0], 1'b0, sb[4:0]};
          fnps_pkg::OPR_DR:     res_data = {3'b000, sa[4:0]};
          fnps_pkg::OPR_SR:     res_data = {3'b000, sa[4:0]};
          fnps_pkg::OPR_SL_RR:  res_data = {sa[3:0], sb[3:0]};
          fnps_pkg::OPR_SSG:    res_data = {4'h0, sa[3:0]};
          default:              res_data = 8'h00;
        endcase
        if (out_free) begin
          load = 1'b1;
          if (grp_cnt == fnps_pkg::OPR_SSG) begin
            if (op_cnt == fnps_pkg::OP_LAST) begin
              state_next = fnps_pkg::ST_PITCH_HI;
            end else begin
              op_cnt_next  = op_cnt + 1'b1;
              grp_cnt_next = fnps_pkg::OPR_DT_MUL;
              rd_en        = 1'b1;
              rd_addr      = fnps_pkg::fnps_op_base(op_cnt_next) +
                             AW'(fnps_pkg::fnps_reg_offset(grp_cnt_next));
            end
          end else begin
            grp_cnt_next = grp_cnt + 1'b1;
            rd_en        = 1'b1;
            rd_addr      = fnps_pkg::fnps_op_base(op_cnt_next) +
                           AW'(fnps_pkg::fnps_reg_offset(grp_cnt_next));
          end
        end
      end

      fnps_pkg::ST_PITCH_HI: begin
        res_addr = fnps_pkg::ADDR_FNUM_HI | {6'b000000, channel};
        res_data = {2'b00, pitch_ent[13:11], pitch_ent[10:8]};
        if (out_free) begin
          load       = 1'b1;
          state_next = fnps_pkg::ST_PITCH_LO;
        end
      end

      fnps_pkg::ST_PITCH_LO: begin
        res_addr = fnps_pkg::ADDR_FNUM_LO | {6'b000000, channel};
        res_data = pitch_ent[7:0];
        res_last = !retrig;
        if (out_free) begin
          load       = 1'b1;
          state_next = retrig ? fnps_pkg::ST_KEYON : fnps_pkg::ST_IDLE;
        end
      end

      fnps_pkg::ST_KEYON: begin
        res_addr = fnps_pkg::ADDR_KEY;
        res_data = fnps_pkg::KEY_ON_MASK | {6'b000000, channel};
        res_last = 1'b1;
        if (out_free) begin
          load       = 1'b1;
          state_next = fnps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = fnps_pkg::ST_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fnps_pkg::ST_IDLE;
      channel      <= fnps_pkg::CHANNEL_RESET;
      active       <= 1'b0;
      last_note    <= '0;
      retrig       <= 1'b0;
      need_koff    <= 1'b0;
      op_cnt       <= '0;
      grp_cnt      <= '0;
      diff         <= '0;
      staged_vld   <= '0;
      result_valid <= 1'b0;
    end else begin
      state     <= state_next;
      active    <= active_next;
      last_note <= last_note_next;
      retrig    <= retrig_next;
      need_koff <= need_koff_next;
      op_cnt    <= op_cnt_next;
      grp_cnt   <= grp_cnt_next;
      if (cfg_valid) begin
        channel <= cfg_channel;
      end
      if (diff_clear) begin
        diff <= '0;
      end else if (wr_upd) begin
        diff[wr_entry] <= new_diff;
      end
      if (wr_upd) begin
        staged_vld[wr_entry] <= 1'b1;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // beat payload latched at the queue head
  always_ff @(posedge clk) begin
    if (q_pop) begin
      note_q   <= q_head.note;
      wr_entry <= q_head.entry;
      wr_value <= q_head.value;
    end
  end

  // patch memories, registered reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a     <= staged_mem[rd_addr];
      rd_b     <= staged_mem[rd_addr_b];
      rd_a_vld <= staged_vld[rd_addr];
      rd_b_vld <= staged_vld[rd_addr_b];
      app_rd   <= applied_mem[rd_addr];
    end
    if (wr_upd) begin
      staged_mem[wr_entry] <= wr_value;
      if (!diff[wr_entry]) begin
        applied_mem[wr_entry] <= sa;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      kind     <= res_kind;
      reg_addr <= res_addr;
      reg_data <= res_data;
      last     <= res_last;
    end
  end

endmodule

FILE: hw/rtl/fm_note_preview_sequencer.sv
// fm_note_preview_sequencer: top level of the fm note preview sequencer
// depends on fnps_pkg, fnps_front, fnps_queue and fnps_back
//
//   channel   handshake                 payload
//   item      item_valid / item_stall   cmd, op_index, param_index, param_value,
//                                       button_now, button_before, note_offset
//   result    result_valid / result_stall  kind, reg_addr, reg_data, last
//   config    cfg_valid / cfg_ready     channel
//
// in the back a parameter write goes through ST_WR_UPD; a frame tick is decided in
// ST_IDLE and then emits its result beats, if any. the one-beat-a-cycle pace while
// result_stall is low comes from the sequencer and the two-port patch read.
// reset is synchronous; patch bytes read as zero until written, no clearing pass.
// result_stall holds the output register and stalls the beat-emitting states; item_stall
// rises only while the beat queue is full.
`timescale 1ns / 1ps

module fm_note_preview_sequencer #(
  parameter int unsigned PITCH_TABLE_DEPTH = fnps_pkg::PITCH_TABLE_DEPTH,
  parameter int unsigned QUEUE_DEPTH       = fnps_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] channel,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       cmd,
  input  logic [1:0] op_index,
  input  logic [3:0] param_index,
  input  logic [7:0] param_value,
  input  logic       button_now,
  input  logic       button_before,
  input  logic [6:0] note_offset,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       kind,
  output logic [7:0] reg_addr,
  output logic [7:0] reg_data,
  output logic       last
);

  fnps_pkg::fnps_item_t push_item;
  fnps_pkg::fnps_item_t head;
  logic q_push, q_full, q_pop, q_empty;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // front: accept and classify
  fnps_front u_front (
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .cmd           (cmd),
    .op_index      (op_index),
    .param_index   (param_index),
    .param_value   (param_value),
    .button_now    (button_now),
    .button_before (button_before),
    .note_offset   (note_offset),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  // queue between front and back
  fnps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty)
  );

  // back: patch store and sequencer
  fnps_back #(
    .PITCH_TABLE_DEPTH (PITCH_TABLE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_channel  (channel),
    .q_empty      (q_empty),
    .q_head       (head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .reg_addr     (reg_addr),
    .reg_data     (reg_data),
    .last         (last)
  );

endmodule

FILE: verif/testbench.sv
// testbench for fm_note_preview_sequencer: directed and random beats checked against
// an in-bench model of the preview key and patch logic, with random idling on both sides
// depends on fnps_pkg and the fm_note_preview_sequencer rtl
`timescale 1ns / 1ps

module testbench;

  localparam int DRAIN_CYCLES = 40;
  localparam int RUN_LIMIT_NS = 10_000_000;
  localparam int PHASE_BEATS  = 100;
  localparam logic [1:0] SLOT_OF_OP [4] = '{2'd0, 2'd2, 2'd1, 2'd3};

  typedef struct packed {
    logic       cmd;
    logic [1:0] op;
    logic [3:0] pidx;
    logic [7:0] pval;
    logic       now;
    logic       prior;
    logic [6:0] note;
  } preview_beat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } fm_write_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] channel = 2'd0;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic       cmd = 1'b0;
  logic [1:0] op_index = 2'd0;
  logic [3:0] param_index = 4'd0;
  logic [7:0] param_value = 8'd0;
  logic       button_now = 1'b0;
  logic       button_before = 1'b0;
  logic [6:0] note_offset = 7'd0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       kind;
  logic [7:0] reg_addr;
  logic [7:0] reg_data;
  logic       last;

  // preview state as the block should hold it
  logic [7:0] staged_bytes [fnps_pkg::PATCH_BYTES];
  logic [7:0] applied_bytes [fnps_pkg::PATCH_BYTES];
  logic       key_active = 1'b0;
  logic [6:0] held_note = 7'd0;
  logic [1:0] cur_channel = fnps_pkg::CHANNEL_RESET;

  fm_write_t fm_writes_due [$];
  int        burst_len;
  bit        quiet = 1'b0;
  int        mismatch_count = 0;
  int        beats_sent = 0;
  int        writes_checked = 0;
  int        channel_writes = 0;

  fm_note_preview_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .channel      (channel),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .op_index     (op_index),
    .param_index  (param_index),
    .param_value  (param_value),
    .button_now   (button_now),
    .button_before(button_before),
    .note_offset  (note_offset),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .reg_addr     (reg_addr),
    .reg_data     (reg_data),
    .last         (last)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // queue one expected fm write or stop beat
  function automatic void push_write(input logic k, input logic [7:0] a, input logic [7:0] d);
    fm_writes_due.push_back('{kind: k, addr: a, data: d, last: 1'b0});
    burst_len++;
  endfunction

  // pitch writes, note clamped to the table
  function automatic void push_pitch(input logic [1:0] ch, input logic [6:0] note);
    int idx;
    logic [13:0] pitch_word;
    idx = int'(note);
    if (idx > int'(fnps_pkg::PITCH_TABLE_DEPTH) - 1)
      idx = int'(fnps_pkg::PITCH_TABLE_DEPTH) - 1;
    if (idx > int'(fnps_pkg::PITCH_ROM_ENTRIES) - 1)
      idx = int'(fnps_pkg::PITCH_ROM_ENTRIES) - 1;
    pitch_word = fnps_pkg::PITCH_ROM[idx];
    push_write(fnps_pkg::KIND_FM_WRITE, fnps_pkg::ADDR_FNUM_HI | 8'(ch),
               {2'b00, pitch_word[13:11], pitch_word[10:8]});
    push_write(fnps_pkg::KIND_FM_WRITE, fnps_pkg::ADDR_FNUM_LO | 8'(ch), pitch_word[7:0]);
  endfunction

  // work out the fm writes one accepted beat causes
  function automatic void predict_fm_writes(input preview_beat_t b);
    logic [1:0] ch;
    bit changed;
    bit retrig;
    bit pitch_only;
    logic [7:0] p [10];
    logic [7:0] d;
    fm_write_t tail;
    ch = cur_channel;
    burst_len = 0;
    if (b.cmd == fnps_pkg::CMD_PARAM) begin
      // patch parameter store, indexes above fb are dropped
      if (b.pidx < 4'd10) staged_bytes[int'(b.op) * 10 + int'(b.pidx)] = b.pval;
      else if (b.pidx == fnps_pkg::PI_ALG) staged_bytes[fnps_pkg::ENTRY_ALG] = b.pval;
      else if (b.pidx == fnps_pkg::PI_FB) staged_bytes[fnps_pkg::ENTRY_FB] = b.pval;
    end else if (!b.now) begin
      // key released
      if (b.prior) push_write(fnps_pkg::KIND_FM_WRITE, fnps_pkg::ADDR_KEY, 8'(ch));
      key_active = 1'b0;
    end else begin
      changed = 1'b0;
      for (int i = 0; i < fnps_pkg::PATCH_BYTES; i++)
        if (staged_bytes[i] != applied_bytes[i]) changed = 1'b1;
      retrig = !b.prior || !key_active || changed;
      pitch_only = !retrig && (b.note != held_note);
      if (retrig) begin
        // full patch load and key-on
        push_write(fnps_pkg::KIND_STOP, 8'd0, 8'd0);
        if (key_active) push_write(fnps_pkg::KIND_FM_WRITE, fnps_pkg::ADDR_KEY, 8'(ch));
        push_write(fnps_pkg::KIND_FM_WRITE, fnps_pkg::ADDR_ALG_FB | 8'(ch),
                   {2'b00, staged_bytes[fnps_pkg::ENTRY_FB][2:0],
                    staged_bytes[fnps_pkg::ENTRY_ALG][2:0]});
        push_write(fnps_pkg::KIND_FM_WRITE, fnps_pkg::ADDR_PAN | 8'(ch), fnps_pkg::DATA_PAN);
        for (int op = 0; op < 4; op++) begin
          for (int k = 0; k < 10; k++) p[k] = staged_bytes[op * 10 + k];
          for (int g = 0; g < 7; g++) begin
            case (3'(g))
              fnps_pkg::OPR_DT_MUL: d = {1'b0, p[0][2:0], p[1][3:0]};
              fnps_pkg::OPR_TL:     d = {1'b0, p[2][6:0]};
              fnps_pkg::OPR_KS_AR:  d = {p[3][1:0], 1'b0, p[4][4:0]};
              fnps_pkg::OPR_DR:     d = {3'b000, p[5][4:0]};
              fnps_pkg::OPR_SR:     d = {3'b000, p[6][4:0]};
              fnps_pkg::OPR_SL_RR:  d = {p[7][3:0], p[8][3:0]};
              fnps_pkg::OPR_SSG:    d = {4'h0, p[9][3:0]};
              default:              d = 8'd0;
            endcase
            push_write(fnps_pkg::KIND_FM_WRITE,
                       {4'(fnps_pkg::OP_ADDR_FIRST + 4'(g)), SLOT_OF_OP[op], ch}, d);
          end
        end
        push_pitch(ch, b.note);
        push_write(fnps_pkg::KIND_FM_WRITE, fnps_pkg::ADDR_KEY,
                   fnps_pkg::KEY_ON_MASK | 8'(ch));
        key_active = 1'b1;
      end else if (pitch_only) begin
        push_pitch(ch, b.note);
      end
      if (retrig || pitch_only) begin
        held_note = b.note;
        for (int i = 0; i < fnps_pkg::PATCH_BYTES; i++) applied_bytes[i] = staged_bytes[i];
      end
    end
    // flag the final beat of the burst
    if (burst_len > 0) begin
      tail = fm_writes_due.pop_back();
      tail.last = 1'b1;
      fm_writes_due.push_back(tail);
    end
  endfunction

  function automatic preview_beat_t frame_beat(input logic now, input logic prior,
                                               input logic [6:0] note);
    frame_beat = '{cmd: fnps_pkg::CMD_FRAME, op: 2'($urandom), pidx: 4'($urandom),
                   pval: 8'($urandom), now: now, prior: prior, note: note};
  endfunction

  function automatic preview_beat_t param_beat(input logic [1:0] op, input logic [3:0] pidx,
                                               input logic [7:0] pval);
    param_beat = '{cmd: fnps_pkg::CMD_PARAM, op: op, pidx: pidx, pval: pval,
                   now: 1'($urandom), prior: 1'($urandom), note: 7'($urandom)};
  endfunction

  // send one input beat, entered and left at a falling edge
  task automatic send_beat(input preview_beat_t b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd           = b.cmd;
    op_index      = b.op;
    param_index   = b.pidx;
    param_value   = b.pval;
    button_now    = b.now;
    button_before = b.prior;
    note_offset   = b.note;
    item_valid    = 1'b1;
    do @(posedge clk); while (item_stall);
    predict_fm_writes(b);
    beats_sent++;
    @(negedge clk);
  endtask

  // wait until every expected beat is out and the block has gone quiet
  task automatic settle();
    item_valid = 1'b0;
    while (fm_writes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_channel(input logic [1:0] value);
    cfg_valid = 1'b1;
    channel   = value;
    do @(posedge clk); while (!cfg_ready);
    cur_channel = value;
    channel_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // key press, hold, note change, release and re-press on the reset channel
  task automatic test_key_transitions();
    send_beat(frame_beat(1'b0, 1'b0, 7'd0));
    send_beat(frame_beat(1'b1, 1'b0, 7'd0));
    send_beat(frame_beat(1'b1, 1'b1, 7'd0));
    send_beat(frame_beat(1'b1, 1'b1, 7'd127));
    send_beat(frame_beat(1'b1, 1'b1, 7'd107));
    send_beat(frame_beat(1'b1, 1'b1, 7'd108));
    send_beat(frame_beat(1'b0, 1'b1, 7'd5));
    send_beat(frame_beat(1'b0, 1'b1, 7'd5));
    send_beat(frame_beat(1'b1, 1'b1, 7'd3));
    send_beat(frame_beat(1'b1, 1'b0, 7'd3));
  endtask

  // all-ones parameters to check field masking, plus dropped indexes
  task automatic test_patch_masking();
    send_beat(param_beat(2'd3, 4'd9, 8'hFF));
    send_beat(param_beat(2'd2, fnps_pkg::PI_ALG, 8'hFF));
    send_beat(param_beat(2'd1, fnps_pkg::PI_FB, 8'hFF));
    send_beat(param_beat(2'd0, 4'd0, 8'hFF));
    send_beat(param_beat(2'd0, 4'd1, 8'hFF));
    send_beat(param_beat(2'd1, 4'd2, 8'hFF));
    send_beat(param_beat(2'd2, 4'd3, 8'hFF));
    send_beat(param_beat(2'd2, 4'd4, 8'hFF));
    send_beat(param_beat(2'd3, 4'd7, 8'hFF));
    send_beat(param_beat(2'd3, 4'd8, 8'hFF));
    send_beat(param_beat(2'd0, 4'd15, 8'hAA));
    send_beat(param_beat(2'd1, 4'd12, 8'h55));
    send_beat(frame_beat(1'b1, 1'b1, 7'd3));
    send_beat(frame_beat(1'b1, 1'b1, 7'd3));
    send_beat(frame_beat(1'b0, 1'b1, 7'd3));
  endtask

  // top and bottom channel values
  task automatic test_channel_settings();
    settle();
    write_channel(2'd3);
    send_beat(frame_beat(1'b1, 1'b0, 7'd12));
    send_beat(frame_beat(1'b0, 1'b1, 7'd12));
    settle();
    write_channel(2'd0);
    send_beat(frame_beat(1'b1, 1'b0, 7'd64));
    send_beat(frame_beat(1'b0, 1'b1, 7'd64));
  endtask

  // mostly consistent key history with random patch edits, some noise
  task automatic test_random();
    logic [1:0] phase_channel [5];
    logic [6:0] note;
    bit held;
    bit now_key;
    bit prior_key;
    int r;
    phase_channel = '{2'd1, 2'd3, 2'd0, 2'd2, 2'($urandom_range(0, 3))};
    note = 7'd0;
    held = 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_channel(phase_channel[ph]);
      quiet = (ph == 2);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 18) begin
          send_beat(param_beat(2'($urandom_range(0, 3)),
                               4'(r < 2 ? $urandom_range(12, 15) : $urandom_range(0, 11)),
                               8'($urandom)));
        end else begin
          if ($urandom_range(0, 3) == 0)
            note = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(0, 24));
          now_key = ($urandom_range(0, 4) != 0);
          prior_key = (r < 94) ? held : 1'($urandom_range(0, 1));
          send_beat(frame_beat(now_key, prior_key, note));
          held = now_key;
        end
      end
    end
    quiet = 1'b0;
  endtask

  // receiver stall, redrawn after every accepted result beat
  always begin
    int hold;
    @(negedge clk);
    hold = quiet ? 0 : $urandom_range(0, 10);
    if (hold > 0) begin
      result_stall = 1'b1;
      repeat (hold) @(negedge clk);
    end
    result_stall = 1'b0;
    do @(posedge clk); while (result_valid !== 1'b1);
  end

  // compare each accepted result beat with the oldest expected one
  always @(posedge clk) begin : check_results
    fm_write_t want;
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      writes_checked++;
      if (fm_writes_due.size() == 0) begin
        $error("unexpected result beat: kind %0h addr %0h data %0h last %0h",
               kind, reg_addr, reg_data, last);
        mismatch_count++;
      end else begin
        want = fm_writes_due.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0h, actual %0h", want.kind, kind);
          mismatch_count++;
        end
        if (reg_addr !== want.addr) begin
          $error("reg_addr: expected %0h, actual %0h", want.addr, reg_addr);
          mismatch_count++;
        end
        if (reg_data !== want.data) begin
          $error("reg_data: expected %0h, actual %0h", want.data, reg_data);
          mismatch_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0h, actual %0h", want.last, last);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  // test sequence
  initial begin
    for (int i = 0; i < fnps_pkg::PATCH_BYTES; i++) begin
      staged_bytes[i]  = 8'd0;
      applied_bytes[i] = 8'd0;
    end
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_key_transitions();
    test_patch_masking();
    test_channel_settings();
    test_random();
    settle();
    $display("summary: %0d input beats sent, %0d result beats checked", beats_sent,
             writes_checked);
    $display("summary: %0d channel writes, covering key edges, patch loads and pitch moves",
             channel_writes);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fnps_pkg.sv
hw/rtl/fnps_front.sv
hw/rtl/fnps_queue.sv
hw/rtl/fnps_back.sv
hw/rtl/fm_note_preview_sequencer.sv
verif/testbench.sv
